@@ design/assert_macros.svh @@
// Assertion macros for the design files; only matrix_row_column_stats uses them.
// Needs nothing else; every macro builds one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, switched off while reset is high.
`define CHK_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequence is checked in the cycle after, switched off while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mrcs_pkg.sv @@
// Shared constants and types for the matrix row and column statistics block.
// Used by the top level and the testbench; depends on nothing.
package mrcs_pkg;

  localparam int MAX_SIZE_DEF = 32;
  localparam int ELEM_W       = 16;
  localparam int SIZE_W       = 6;
  localparam int INDEX_W      = 5;
  localparam int STAT_W       = 24;
  localparam int FRAC_W       = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_ACC    = 10'b0000000010,
    S_COL_RD = 10'b0000000100,
    S_COL_LD = 10'b0000001000,
    S_MUL    = 10'b0000010000,
    S_SUB    = 10'b0000100000,
    S_SQRT   = 10'b0001000000,
    S_DIVD   = 10'b0010000000,
    S_DIVM   = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

endpackage

@@ design/matrix_row_column_stats.sv @@
// Row and column mean and population deviation of a square matrix given in row-major order.
// Each element is accepted, then added into its column RAM entry by a read-modify-write. The
// element that ends a row adds one statistics pass (multiply by shift-add, subtract, root,
// divide for the deviation, divide for the mean, output) in the shared unit; after the last
// row each column takes such a pass after its RAM read and load states. Results wait in an
// output register so that elements keep flowing while a result is pending. Depends on
// mrcs_pkg, mrcs_ram and assert_macros.svh.
`include "assert_macros.svh"

module matrix_row_column_stats #(
  parameter int MAX_SIZE = mrcs_pkg::MAX_SIZE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   matrix_size_wr_en,
  input  logic [mrcs_pkg::SIZE_W-1:0]            matrix_size,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mrcs_pkg::ELEM_W-1:0]     element_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   is_column,
  output logic [mrcs_pkg::INDEX_W-1:0]           line_index,
  output logic signed [mrcs_pkg::STAT_W-1:0]     mean_q8,
  output logic [mrcs_pkg::STAT_W-1:0]            deviation_q8,
  output logic                                   last
);

  localparam int IW    = $clog2(MAX_SIZE);
  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int SUM_W = mrcs_pkg::ELEM_W + IW;
  localparam int SQ_W  = 2 * mrcs_pkg::ELEM_W - 1 + IW;
  localparam int DW    = NW + SQ_W + 1;
  localparam int XW    = DW + 16 + (DW % 2);
  localparam int RW    = XW / 2;
  localparam int QW    = (RW > SUM_W + mrcs_pkg::FRAC_W) ? RW : SUM_W + mrcs_pkg::FRAC_W;
  localparam int ITW   = $clog2(XW + 1);
  localparam int CW    = SUM_W + SQ_W;

  mrcs_pkg::state_t state;

  logic [mrcs_pkg::SIZE_W-1:0] msz;
  logic [NW-1:0]               n;
  logic [IW-1:0]               col_pos, row_pos, k;
  logic signed [SUM_W-1:0]     row_total;
  logic [SQ_W-1:0]             row_sq;
  logic [MAX_SIZE-1:0]         col_vld;
  logic signed [mrcs_pkg::ELEM_W-1:0] elem;
  logic                        last_row, line_col;
  logic [IW-1:0]               line;
  logic [ITW-1:0]              cnt;

  logic                        neg;
  logic [SUM_W-1:0]            mag;
  logic [2*SUM_W-1:0]          magsq;
  logic [DW-1:0]               acc, mcand;
  logic [NW-1:0]               nsh;
  logic [XW-1:0]               x;
  logic [RW+2:0]               rem;
  logic [RW-1:0]               root;
  logic [QW-1:0]               qd;
  logic [NW:0]                 remd;
  logic [RW-1:0]               dev;

  // Column RAM and its ports.
  logic            ram_we;
  logic [IW-1:0]   ram_raddr;
  logic [CW-1:0]   ram_wdata, ram_rdata;

  always_comb begin
    if (msz == '0) begin
      n = NW'(1);
    end else if (32'(msz) > MAX_SIZE) begin
      n = NW'(MAX_SIZE);
    end else begin
      n = NW'(msz);
    end
  end

  // Element accumulation.
  logic signed [SUM_W-1:0] col_sum_rd, col_sum_new, row_total_new;
  logic [SQ_W-1:0]         col_sq_rd, col_sq_new, row_sq_new, elem_sq;
  logic signed [2*mrcs_pkg::ELEM_W-1:0] elem_prod;
  logic                    row_end, col_mask;

  assign elem_prod     = elem * elem;
  assign elem_sq       = SQ_W'(elem_prod);
  assign col_mask      = (state == mrcs_pkg::S_ACC) ? col_vld[col_pos] : col_vld[k];
  assign col_sum_rd    = col_mask ? ram_rdata[SQ_W +: SUM_W] : '0;
  assign col_sq_rd     = col_mask ? ram_rdata[SQ_W-1:0] : '0;
  assign col_sum_new   = col_sum_rd + SUM_W'(elem);
  assign col_sq_new    = col_sq_rd + elem_sq;
  assign row_total_new = row_total + SUM_W'(elem);
  assign row_sq_new    = row_sq + elem_sq;
  assign row_end       = NW'(col_pos) == NW'(n - 1'b1);

  assign ram_we    = (state == mrcs_pkg::S_ACC);
  assign ram_wdata = {col_sum_new, col_sq_new};
  assign ram_raddr = (state == mrcs_pkg::S_IDLE) ? col_pos : k;

  mrcs_ram #(
    .WIDTH(CW),
    .DEPTH(MAX_SIZE)
  ) u_col_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(col_pos),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Values that start a statistics pass, from the row totals or from a column entry.
  logic signed [SUM_W-1:0] ld_s1;
  logic [SQ_W-1:0]         ld_s2;

  assign ld_s1 = (state == mrcs_pkg::S_ACC) ? row_total_new : col_sum_rd;
  assign ld_s2 = (state == mrcs_pkg::S_ACC) ? row_sq_new : col_sq_rd;

  // One root digit per cycle.
  logic [RW+2:0] sq_rs, sq_trial, rem_next;
  logic [RW-1:0] root_next;
  logic          sq_ge;

  assign sq_rs     = {rem[RW:0], x[XW-1:XW-2]};
  assign sq_trial  = {1'b0, root, 2'b01};
  assign sq_ge     = sq_rs >= sq_trial;
  assign rem_next  = sq_ge ? sq_rs - sq_trial : sq_rs;
  assign root_next = {root[RW-2:0], sq_ge};

  // One quotient bit per cycle by the effective size.
  logic [NW:0]   dv_t, remd_next;
  logic [QW-1:0] qd_next;
  logic          dv_ge;

  assign dv_t      = {remd[NW-1:0], qd[QW-1]};
  assign dv_ge     = dv_t >= {1'b0, n};
  assign remd_next = dv_ge ? dv_t - {1'b0, n} : dv_t;
  assign qd_next   = {qd[QW-2:0], dv_ge};

  logic [QW-1:0] mean_full;
  logic          out_free, col_last;

  assign mean_full = neg ? (~qd + 1'b1) : qd;
  assign out_free  = !out_valid || out_ready;
  assign col_last  = NW'(k) == NW'(n - 1'b1);
  assign in_ready  = (state == mrcs_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrcs_pkg::S_IDLE;
      msz       <= mrcs_pkg::SIZE_RESET;
      col_pos   <= '0;
      row_pos   <= '0;
      k         <= '0;
      row_total <= '0;
      row_sq    <= '0;
      col_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new result in the output stage takes over the register instead.
      if (out_valid && out_ready && state != mrcs_pkg::S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        mrcs_pkg::S_IDLE: begin
          if (in_valid) begin
            elem  <= element_value;
            state <= mrcs_pkg::S_ACC;
          end
        end
        mrcs_pkg::S_ACC: begin
          col_vld[col_pos] <= 1'b1;
          if (row_end) begin
            row_total <= '0;
            row_sq    <= '0;
            col_pos   <= '0;
            line_col  <= 1'b0;
            line      <= row_pos;
            last_row  <= NW'(row_pos) == NW'(n - 1'b1);
            row_pos   <= (NW'(row_pos) == NW'(n - 1'b1)) ? '0 : row_pos + 1'b1;
            state     <= mrcs_pkg::S_MUL;
          end else begin
            row_total <= row_total_new;
            row_sq    <= row_sq_new;
            col_pos   <= col_pos + 1'b1;
            state     <= mrcs_pkg::S_IDLE;
          end
        end
        mrcs_pkg::S_COL_RD: begin
          state <= mrcs_pkg::S_COL_LD;
        end
        mrcs_pkg::S_COL_LD: begin
          line_col <= 1'b1;
          line     <= k;
          state    <= mrcs_pkg::S_MUL;
        end
        mrcs_pkg::S_MUL: begin
          magsq <= mag * mag;
          if (nsh[0]) begin
            acc <= acc + mcand;
          end
          mcand <= mcand << 1;
          nsh   <= nsh >> 1;
          cnt   <= cnt + 1'b1;
          if (cnt == ITW'(NW - 1)) begin
            state <= mrcs_pkg::S_SUB;
          end
        end
        mrcs_pkg::S_SUB: begin
          x     <= XW'(acc - DW'(magsq)) << 16;
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= mrcs_pkg::S_SQRT;
        end
        mrcs_pkg::S_SQRT: begin
          rem  <= rem_next;
          root <= root_next;
          x    <= x << 2;
          cnt  <= cnt + 1'b1;
          if (cnt == ITW'(RW - 1)) begin
            qd    <= QW'(root_next);
            remd  <= '0;
            cnt   <= '0;
            state <= mrcs_pkg::S_DIVD;
          end
        end
        mrcs_pkg::S_DIVD: begin
          remd <= remd_next;
          qd   <= qd_next;
          cnt  <= cnt + 1'b1;
          if (cnt == ITW'(QW - 1)) begin
            dev   <= RW'(qd_next);
            qd    <= QW'({mag, {mrcs_pkg::FRAC_W{1'b0}}});
            remd  <= '0;
            cnt   <= '0;
            state <= mrcs_pkg::S_DIVM;
          end
        end
        mrcs_pkg::S_DIVM: begin
          remd <= remd_next;
          qd   <= qd_next;
          cnt  <= cnt + 1'b1;
          if (cnt == ITW'(QW - 1)) begin
            state <= mrcs_pkg::S_OUT;
          end
        end
        mrcs_pkg::S_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            is_column    <= line_col;
            line_index   <= mrcs_pkg::INDEX_W'(line);
            mean_q8      <= mrcs_pkg::STAT_W'(mean_full);
            deviation_q8 <= mrcs_pkg::STAT_W'(dev);
            last         <= line_col && col_last;
            if (!line_col) begin
              k     <= '0;
              state <= last_row ? mrcs_pkg::S_COL_RD : mrcs_pkg::S_IDLE;
            end else if (col_last) begin
              // The whole matrix is out: forget every column for the next one.
              col_vld <= '0;
              k       <= '0;
              state   <= mrcs_pkg::S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= mrcs_pkg::S_COL_RD;
            end
          end
        end
        default: begin
          state <= mrcs_pkg::S_IDLE;
        end
      endcase

      // Loading the operands of a statistics pass, shared by rows and columns.
      if ((state == mrcs_pkg::S_ACC && row_end) || state == mrcs_pkg::S_COL_LD) begin
        neg   <= ld_s1 < 0;
        mag   <= (ld_s1 < 0) ? SUM_W'(-ld_s1) : SUM_W'(ld_s1);
        mcand <= DW'(ld_s2);
        nsh   <= n;
        acc   <= '0;
        cnt   <= '0;
      end

      // A size write starts a fresh matrix; the user must write it only while the block is idle (not enforced here).
      if (matrix_size_wr_en) begin
        msz       <= matrix_size;
        col_pos   <= '0;
        row_pos   <= '0;
        row_total <= '0;
        row_sq    <= '0;
        col_vld   <= '0;
      end
    end
  end

  `CHK_NEXT(a_accept_to_acc, clk, rst, in_valid && in_ready, state == mrcs_pkg::S_ACC, "element not accumulated after its transaction")
  `CHK_IMPL(a_last_is_col, clk, rst, out_valid && last, is_column, "last marked on a row result")
  `CHK_IMPL(a_col_written, clk, rst, state == mrcs_pkg::S_COL_LD, col_vld[k], "column read before it was accumulated")

endmodule

@@ design/mrcs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module mrcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for matrix_row_column_stats: drives matrices of elements and
// compares every row and column statistic with an internal predictor.
// Depends on mrcs_pkg and the design files only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                               is_col;
    logic [mrcs_pkg::INDEX_W-1:0]       idx;
    logic signed [mrcs_pkg::STAT_W-1:0] mean;
    logic [mrcs_pkg::STAT_W-1:0]        dev;
    logic                               fin;
  } line_stat_t;

  class stats_scoreboard;
    int unsigned        size_reg;
    longint             row_sum;
    longint unsigned    row_sq;
    longint             col_sum[mrcs_pkg::MAX_SIZE_DEF];
    longint unsigned    col_sq[mrcs_pkg::MAX_SIZE_DEF];
    int unsigned        col_pos;
    int unsigned        row_pos;
    line_stat_t         pending[$];
    int                 errors;

    function void clear_sums();
      row_sum = 0;
      row_sq = 0;
      for (int i = 0; i < mrcs_pkg::MAX_SIZE_DEF; i++) begin
        col_sum[i] = 0;
        col_sq[i] = 0;
      end
      col_pos = 0;
      row_pos = 0;
    endfunction

    function void set_size(int unsigned v);
      size_reg = v & 63;
      clear_sums();
    endfunction

    function int unsigned active_size();
      if (size_reg == 0) return 1;
      if (size_reg > mrcs_pkg::MAX_SIZE_DEF) return mrcs_pkg::MAX_SIZE_DEF;
      return size_reg;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void push_stat(bit col, int unsigned idx, longint s1, longint unsigned s2,
                            int unsigned n, bit fin);
      line_stat_t      s;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned d;
      mag = (s1 < 0) ? longint'(-s1) : longint'(s1);
      q = (mag * 256) / n;
      d = n * s2 - mag * mag;
      s.is_col = col;
      s.idx = idx[mrcs_pkg::INDEX_W-1:0];
      s.mean = (s1 < 0) ? mrcs_pkg::STAT_W'(-q) : mrcs_pkg::STAT_W'(q);
      s.dev = mrcs_pkg::STAT_W'(int_sqrt(d * 65536) / n);
      s.fin = fin;
      pending.push_back(s);
    endfunction

    function void note_element(logic signed [mrcs_pkg::ELEM_W-1:0] e);
      int unsigned n;
      longint      v;
      n = active_size();
      if (col_pos >= n) col_pos = 0;
      if (row_pos >= n) row_pos = 0;
      v = e;
      row_sum += v;
      row_sq += v * v;
      col_sum[col_pos] += v;
      col_sq[col_pos] += v * v;
      if (col_pos + 1 < n) begin
        col_pos++;
        return;
      end
      push_stat(0, row_pos, row_sum, row_sq, n, 0);
      row_sum = 0;
      row_sq = 0;
      col_pos = 0;
      if (row_pos + 1 < n) begin
        row_pos++;
        return;
      end
      for (int i = 0; i < n; i++)
        push_stat(1, i, col_sum[i], col_sq[i], n, i + 1 == n);
      clear_sums();
    endfunction

    function void check_result(line_stat_t got);
      line_stat_t w;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.is_col !== w.is_col) begin
        $error("is_column expected %0d actual %0d", w.is_col, got.is_col); errors++;
      end
      if (got.idx !== w.idx) begin
        $error("line_index expected %0d actual %0d", w.idx, got.idx); errors++;
      end
      if (got.mean !== w.mean) begin
        $error("mean_q8 expected %0d actual %0d", w.mean, got.mean); errors++;
      end
      if (got.dev !== w.dev) begin
        $error("deviation_q8 expected %0d actual %0d", w.dev, got.dev); errors++;
      end
      if (got.fin !== w.fin) begin
        $error("last expected %0d actual %0d", w.fin, got.fin); errors++;
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst;
  logic                               matrix_size_wr_en;
  logic [mrcs_pkg::SIZE_W-1:0]        matrix_size;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [mrcs_pkg::ELEM_W-1:0] element_value;
  logic                               out_valid;
  logic                               out_ready;
  logic                               is_column;
  logic [mrcs_pkg::INDEX_W-1:0]       line_index;
  logic signed [mrcs_pkg::STAT_W-1:0] mean_q8;
  logic [mrcs_pkg::STAT_W-1:0]        deviation_q8;
  logic                               last;

  stats_scoreboard sb;
  int  idle_cycles;
  bit  hold_off;
  bit  hold_req;

  matrix_row_column_stats i_dut (
    .clk(clk), .rst(rst),
    .matrix_size_wr_en(matrix_size_wr_en), .matrix_size(matrix_size),
    .in_valid(in_valid), .in_ready(in_ready), .element_value(element_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_column(is_column), .line_index(line_index), .mean_q8(mean_q8),
    .deviation_q8(deviation_q8), .last(last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    rst = 1'b1;
    matrix_size_wr_en = 1'b0;
    matrix_size = '0;
    in_valid = 1'b0;
    element_value = '0;
    out_ready = 1'b0;
  end

  // Valid only drops when a gap is drawn, so back-to-back elements keep it high.
  task automatic send_element(logic signed [mrcs_pkg::ELEM_W-1:0] e);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element_value <= e;
    do @(posedge clk); while (!in_ready);
    sb.note_element(e);
  endtask

  // Waits for all outstanding results, then for the tail of any pass still running.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_size(logic [mrcs_pkg::SIZE_W-1:0] v);
    matrix_size_wr_en <= 1'b1;
    matrix_size <= v;
    @(posedge clk);
    matrix_size_wr_en <= 1'b0;
    sb.set_size(v);
  endtask

  function automatic logic signed [mrcs_pkg::ELEM_W-1:0] rand_element(int mode);
    case (mode)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return mrcs_pkg::ELEM_W'($urandom_range(0, 15)) - 16'sd8;
      default: return mrcs_pkg::ELEM_W'($urandom());
    endcase
  endfunction

  task automatic send_matrix(int n, int mode);
    for (int i = 0; i < n * n; i++) send_element(rand_element(mode));
  endtask

  // Receiver: random stalls per transaction, plus one long hold-off requested by the sender.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result('{is_column, line_index, mean_q8, deviation_q8, last});
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (idle_cycles > 0) begin
        idle_cycles <= idle_cycles - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        idle_cycles <= $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // The hold-off lasts long enough for results to back up and block the input.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog on cycles without any accepted transaction.
  int unsigned quiet;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 200000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    sb = new();
    sb.set_size(mrcs_pkg::SIZE_RESET);
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes in a 2x2, a single element, an out-of-range size and zero size.
    write_size(6'd2);
    send_element(16'sh7FFF); send_element(16'sh8000);
    send_element(16'sh8000); send_element(16'sh8000);
    drain();
    write_size(6'd1);
    send_element(16'sh8000);
    drain();
    write_size(6'd0);
    send_element(16'sh7FFF);
    send_element(-16'sd3);
    drain();
    write_size(6'd63);
    send_matrix(1, 0);
    drain();
    // Size rewritten part way through a matrix abandons the partial sums.
    write_size(6'd3);
    send_element(16'sd5); send_element(-16'sd7); send_element(16'sd9); send_element(16'sd1);
    drain();
    write_size(6'd3);
    send_matrix(3, 1);
    drain();

    // Random small matrices, then a larger one made of the most negative element.
    for (int k = 0; k < 13; k++) begin
      n = $urandom_range(1, 4);
      write_size(mrcs_pkg::SIZE_W'(n));
      send_matrix(n, ($urandom_range(0, 3) == 0) ? 0 : 3);
      drain();
    end
    write_size(6'd6);
    send_matrix(6, 1);
    drain();

    // A stream of 2x2 matrices while the receiver holds off for a long stretch.
    write_size(6'd2);
    hold_req = 1'b1;
    for (int k = 0; k < 20; k++) send_matrix(2, $urandom_range(0, 3));
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
